// ===== sv/tmcg_pkg.sv =====
// shared types, constants and a helper function for the text mode character generator
package tmcg_pkg;

   localparam int ADDR_W      = 11;
   localparam int BYTE_W      = 8;
   localparam int GLYPH_DEPTH = 2048;
   localparam int ROW_SEL_W   = 3;
   localparam int START_W     = 14;

   typedef enum logic [2:0] {
      ACT_ADDR_LOW    = 3'd0,
      ACT_CONTROL     = 3'd1,
      ACT_VIDEO_WRITE = 3'd2,
      ACT_GLYPH_LOAD  = 3'd3,
      ACT_RENDER      = 3'd4
   } action_type;

   // one write request into the glyph store
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } glyph_wr_type;

   // remainder of an 11-bit address by a depth of 256 to 2048,
   // three restoring compare and subtract steps (quotient below 8)
   function automatic logic [ADDR_W-1:0] mod_depth(input logic [ADDR_W-1:0] value,
                                                   input logic [START_W-1:0] depth);
      logic [START_W-1:0] rem;
      rem = {{(START_W-ADDR_W){1'b0}}, value};
      for (int k = 2; k >= 0; k--) begin
         if (rem >= (depth << k)) begin
            rem = rem - (depth << k);
         end
      end
      return rem[ADDR_W-1:0];
   endfunction

endpackage

// ===== sv/tmcg_video_mem.sv =====
// video store with a clearing sweep after reset
module tmcg_video_mem #(
   parameter int VIDEO_DEPTH = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [$clog2(VIDEO_DEPTH)-1:0] wr_addr,
   input  logic [tmcg_pkg::BYTE_W-1:0]    wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(VIDEO_DEPTH)-1:0] rd_addr,
   output logic [tmcg_pkg::BYTE_W-1:0]    rd_data,
   output logic                           busy
);

   localparam int VIDX_W = $clog2(VIDEO_DEPTH);
   localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VIDEO_DEPTH - 1);

   logic [tmcg_pkg::BYTE_W-1:0] mem [VIDEO_DEPTH];
   logic                        clear_ff;
   logic                        clear_in;
   logic [VIDX_W-1:0]           clr_addr_ff;
   logic [VIDX_W-1:0]           clr_addr_in;
   logic [tmcg_pkg::BYTE_W-1:0] rd_data_ff;

   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == LAST_IDX) begin
            clear_in    = 1'b0;
            clr_addr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clear_ff;

endmodule

// ===== sv/tmcg_glyph_mem.sv =====
// glyph store, eight rows per character
module tmcg_glyph_mem (
   input  logic                         clock,
   input  tmcg_pkg::glyph_wr_type       wr,
   input  logic                         rd_en,
   input  logic [tmcg_pkg::ADDR_W-1:0]  rd_addr,
   output logic [tmcg_pkg::BYTE_W-1:0]  rd_data
);

   logic [tmcg_pkg::BYTE_W-1:0] mem [tmcg_pkg::GLYPH_DEPTH];
   logic [tmcg_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/text_mode_character_generator.sv =====
// top level of the text mode character generator
// The block takes one transaction per clock while req_ready is high and
// answers a render transaction through the video store read, the glyph store
// read and the output register; other actions give no result. Throughput is
// set by the single read port of each memory, one read per cycle each. After
// reset the video store is swept to zero one byte a cycle, and req_ready
// stays low until the sweep is done. When rsp_ready is low while a result
// waits, the whole pipe holds and req_ready drops. Video store writes and reads
// and glyph store loads take place at accept edges in transaction order; a
// glyph read trails its render, at an edge on which the pipe moves, and sees
// the store as it was before any later load, so no forwarding is needed. Glyph
// rows must be loaded before they are rendered.
module text_mode_character_generator #(
   parameter int VIDEO_DEPTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_data,
   input  logic [10:0] req_glyph_address,
   input  logic [13:0] req_row_start,
   input  logic [7:0]  req_column,
   input  logic [4:0]  req_raster,
   input  logic [7:0]  req_cursor_column,
   input  logic        req_row_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_pixels,
   output logic        rsp_row_last
);

   localparam int VIDX_W = $clog2(VIDEO_DEPTH);
   localparam int AW     = tmcg_pkg::ADDR_W;
   localparam int BW     = tmcg_pkg::BYTE_W;
   localparam int RW     = tmcg_pkg::ROW_SEL_W;
   localparam int SW     = tmcg_pkg::START_W;

   // bus latches
   logic [BW-1:0] addr_low_ff;
   logic [BW-1:0] addr_low_in;
   logic [BW-1:0] control_ff;
   logic [BW-1:0] control_in;

   // pipe control
   logic advance;
   logic accept;
   logic clearing;
   logic is_render;

   // stage 1: video byte being read
   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic [RW-1:0] s1_row_ff;
   logic          s1_blank_ff;
   logic          s1_inv_ff;
   logic          s1_last_ff;

   // stage 2: glyph row being read
   logic          s2_valid_ff;
   logic          s2_blank_ff;
   logic          s2_inv_ff;
   logic          s2_last_ff;

   // output register
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [BW-1:0] rsp_pixels_ff;
   logic [BW-1:0] rsp_pixels_in;
   logic          rsp_last_ff;

   // memory ports
   logic [AW-1:0]          wr_addr11;
   logic [AW-1:0]          rd_addr11;
   logic [SW-1:0]          cell_sum;
   logic [VIDX_W-1:0]      video_wr_addr;
   logic [VIDX_W-1:0]      video_rd_addr;
   logic                   video_wr_en;
   logic [BW-1:0]          char_code;
   logic [BW-1:0]          glyph_row;
   logic [AW-1:0]          glyph_rd_addr;
   tmcg_pkg::glyph_wr_type glyph_wr;

   // the whole pipe moves when the output slot is free or being emptied
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && !clearing;
   assign accept    = req_valid && req_ready;
   assign is_render = (req_action == tmcg_pkg::ACT_RENDER);

   // latch writes
   always_comb begin
      addr_low_in = addr_low_ff;
      control_in  = control_ff;
      if (accept && req_action == tmcg_pkg::ACT_ADDR_LOW) begin
         addr_low_in = req_data;
      end
      if (accept && req_action == tmcg_pkg::ACT_CONTROL) begin
         control_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_low_ff <= '0;
         control_ff  <= '0;
      end else begin
         addr_low_ff <= addr_low_in;
         control_ff  <= control_in;
      end
   end

   // video store addresses, folded into the store depth
   assign wr_addr11     = {control_ff[2:0], addr_low_ff};
   assign cell_sum      = req_row_start + {{(SW-BW){1'b0}}, req_column};
   assign rd_addr11     = cell_sum[AW-1:0];
   assign video_wr_addr = VIDX_W'(tmcg_pkg::mod_depth(wr_addr11, SW'(VIDEO_DEPTH)));
   assign video_rd_addr = VIDX_W'(tmcg_pkg::mod_depth(rd_addr11, SW'(VIDEO_DEPTH)));
   assign video_wr_en   = accept && (req_action == tmcg_pkg::ACT_VIDEO_WRITE);

   tmcg_video_mem #(
      .VIDEO_DEPTH(VIDEO_DEPTH)
   ) u_video (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (video_wr_en),
      .wr_addr(video_wr_addr),
      .wr_data(req_data),
      .rd_en  (accept && is_render),
      .rd_addr(video_rd_addr),
      .rd_data(char_code),
      .busy   (clearing)
   );

   // glyph store: load on accept, read row of the character from stage 1
   assign glyph_wr.en   = accept && (req_action == tmcg_pkg::ACT_GLYPH_LOAD);
   assign glyph_wr.addr = req_glyph_address;
   assign glyph_wr.data = req_data;
   assign glyph_rd_addr = {char_code, s1_row_ff};

   tmcg_glyph_mem u_glyph (
      .clock  (clock),
      .wr     (glyph_wr),
      .rd_en  (advance && s1_valid_ff),
      .rd_addr(glyph_rd_addr),
      .rd_data(glyph_row)
   );

   // stage valids
   assign s1_valid_in  = advance ? (accept && is_render) : s1_valid_ff;
   assign rsp_valid_in = advance ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         if (advance) begin
            s2_valid_ff <= s1_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // blank raster gives the cursor mask alone
   always_comb begin
      if (s2_blank_ff) begin
         rsp_pixels_in = {BW{s2_inv_ff}};
      end else begin
         rsp_pixels_in = glyph_row ^ {BW{s2_inv_ff}};
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_row_ff     <= req_raster[RW-1:0];
         s1_blank_ff   <= (req_raster[4:RW] != '0);
         s1_inv_ff     <= (req_column == req_cursor_column);
         s1_last_ff    <= req_row_end;
         s2_blank_ff   <= s1_blank_ff;
         s2_inv_ff     <= s1_inv_ff;
         s2_last_ff    <= s1_last_ff;
         rsp_pixels_ff <= rsp_pixels_in;
         rsp_last_ff   <= s2_last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pixels   = rsp_pixels_ff;
   assign rsp_row_last = rsp_last_ff;

   // no transaction is taken during the clearing sweep
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("transaction accepted during video store clear");

   // a render enters stage 1
   a_render_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && is_render) |=> s1_valid_ff)
      else $error("render transaction lost at stage 1");

   // a result in stage 2 reaches the output when the pipe moves
   a_stage2_to_out: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff) |=> rsp_valid_ff)
      else $error("result lost between stage 2 and output");

   // blank raster lines carry only the cursor mask
   a_blank_pixels: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff && s2_blank_ff) |=>
      (rsp_pixels_ff == ($past(s2_inv_ff) ? 8'hff : 8'h00)))
      else $error("blank raster line gives glyph data");

endmodule
